// ===== rtl/trs_pkg.sv =====
// Shared types, widths and register codes for the triangle row span block.
// No dependencies; imported by every module of the block except trs_out_buf.
package trs_pkg;

    localparam int COORD_MAX = 4096;

    localparam int CRD_W     = 13;  // x/y origin, signed
    localparam int SIDE_W    = 13;
    localparam int ROW_W     = 12;
    localparam int PIX_W     = 12;  // output coordinates
    localparam int REG_W     = 13;  // config registers
    localparam int CFG_IDX_W = 1;

    localparam int SQ_W      = 2 * SIDE_W;   // side^2
    localparam int RAD_W     = SQ_W + 2;     // 3*side^2
    localparam int ROOT_W    = RAD_W / 2;    // isqrt result
    localparam int ISQ_REM_W = ROOT_W + 2;
    localparam int H_W       = ROOT_W - 1;   // triangle height
    localparam int DEN_W     = ROOT_W;       // 2*height
    localparam int NUM_W     = 25;           // (row+1)*side, below 2^25

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PAGE_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_PAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic [SIDE_W-1:0]       s;
        logic [ROW_W-1:0]        r;
    } t_item;

    // travels alongside the square root
    typedef struct packed {
        t_item             item;
        logic [NUM_W-1:0]  num;
        logic              off_xy;
    } t_root_sb;

    // travels alongside the divider
    typedef struct packed {
        t_item item;
        logic  off;
        logic  go;
    } t_span_sb;

    typedef struct packed {
        logic             off;
        logic             valid;
        logic [PIX_W-1:0] row_y;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] left;
    } t_result;

endpackage

// ===== rtl/trs_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on trs_pkg; carries an opaque sideband word alongside.
module trs_isqrt #(
    parameter int SB_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [trs_pkg::RAD_W-1:0]  i_rad,
    input  logic [SB_W-1:0]            i_sb,
    output logic                       o_vld,
    output logic [trs_pkg::ROOT_W-1:0] o_root,
    output logic [SB_W-1:0]            o_sb
);
    import trs_pkg::*;

    localparam int N = ROOT_W;

    logic                 s_vld  [0:N];
    logic [RAD_W-1:0]     s_rad  [0:N];
    logic [ISQ_REM_W-1:0] s_rem  [0:N];
    logic [ROOT_W-1:0]    s_root [0:N];
    logic [SB_W-1:0]      s_sb   [0:N];

    assign s_vld[0]  = i_vld;
    assign s_rad[0]  = i_rad;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_sb[0]   = i_sb;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [ISQ_REM_W+1:0] w_sh;
        logic [ISQ_REM_W+1:0] w_trial;
        logic                 r_vld;
        logic [RAD_W-1:0]     r_rad;
        logic [ISQ_REM_W-1:0] r_rem;
        logic [ROOT_W-1:0]    r_root;
        logic [SB_W-1:0]      r_sb;

        // bring down the next two radicand bits, try root*4+1
        assign w_sh    = {s_rem[k], s_rad[k][RAD_W-1 -: 2]};
        assign w_trial = {2'b00, s_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad <= s_rad[k] << 2;
                r_sb  <= s_sb[k];
                if (w_sh >= w_trial) begin
                    r_rem  <= ISQ_REM_W'(w_sh - w_trial);
                    r_root <= {s_root[k][ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= ISQ_REM_W'(w_sh);
                    r_root <= {s_root[k][ROOT_W-2:0], 1'b0};
                end
            end
        end

        assign s_vld[k+1]  = r_vld;
        assign s_rad[k+1]  = r_rad;
        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_sb[k+1]   = r_sb;
    end

    assign o_vld  = s_vld[N];
    assign o_root = s_root[N];
    assign o_sb   = s_sb[N];

endmodule

// ===== rtl/trs_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on trs_pkg; carries an opaque sideband word alongside.
module trs_div #(
    parameter int SB_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [trs_pkg::NUM_W-1:0] i_num,
    input  logic [trs_pkg::DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]           i_sb,
    output logic                      o_vld,
    output logic [trs_pkg::NUM_W-1:0] o_quot,
    output logic [trs_pkg::DEN_W-1:0] o_rem,
    output logic [SB_W-1:0]           o_sb
);
    import trs_pkg::*;

    localparam int N = NUM_W;

    logic             s_vld [0:N];
    logic [NUM_W-1:0] s_num [0:N];
    logic [DEN_W-1:0] s_den [0:N];
    logic [DEN_W-1:0] s_rem [0:N];
    logic [NUM_W-1:0] s_quot[0:N];
    logic [SB_W-1:0]  s_sb  [0:N];

    assign s_vld[0]  = i_vld;
    assign s_num[0]  = i_num;
    assign s_den[0]  = i_den;
    assign s_rem[0]  = '0;
    assign s_quot[0] = '0;
    assign s_sb[0]   = i_sb;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [DEN_W:0]   w_sh;
        logic             w_ge;
        logic             r_vld;
        logic [NUM_W-1:0] r_num;
        logic [DEN_W-1:0] r_den;
        logic [DEN_W-1:0] r_rem;
        logic [NUM_W-1:0] r_quot;
        logic [SB_W-1:0]  r_sb;

        assign w_sh = {s_rem[k], s_num[k][NUM_W-1]};
        assign w_ge = (w_sh >= {1'b0, s_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num  <= s_num[k] << 1;
                r_den  <= s_den[k];
                r_sb   <= s_sb[k];
                r_quot <= {s_quot[k][NUM_W-2:0], w_ge};
                if (w_ge) begin
                    r_rem <= DEN_W'(w_sh - {1'b0, s_den[k]});
                end else begin
                    r_rem <= DEN_W'(w_sh);
                end
            end
        end

        assign s_vld[k+1]  = r_vld;
        assign s_num[k+1]  = r_num;
        assign s_den[k+1]  = r_den;
        assign s_rem[k+1]  = r_rem;
        assign s_quot[k+1] = r_quot;
        assign s_sb[k+1]   = r_sb;
    end

    assign o_vld  = s_vld[N];
    assign o_quot = s_quot[N];
    assign o_rem  = s_rem[N];
    assign o_sb   = s_sb[N];

endmodule

// ===== rtl/trs_out_buf.sv =====
// Two-entry output buffer that decouples the pipeline from the output stall.
// No package dependency; the pipeline runs whenever a slot is free.
module trs_out_buf #(
    parameter int W = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_ready,
    output logic         o_space,
    output logic         o_vld,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [0:1];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_cnt;
    logic         w_pop;

    assign o_vld   = (r_cnt != 2'd0);
    assign o_space = (r_cnt != 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_vld & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/triangle_row_span.sv =====
// Throughput: one transaction per cycle while the output buffer has a free
// slot, set by the fully pipelined square root (14 stages) and divider (25
// stages); 3 front stages, 1 stage between root and divider, 1 result stage
// and the output buffer.
// Reset (synchronous, active low): pipeline and output buffer empty,
// page_width and page_height back to 1024.
module triangle_row_span (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // x_origin[12:0], y_origin[25:13], side_length[38:26], row_offset[50:39]
    input  logic [trs_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // span_left[11:0], span_right[23:12], row_y[35:24]
    output logic [trs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // row_valid[0], off_page[1]
    output logic [trs_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          i_cfg_we,
    input  logic [trs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [trs_pkg::REG_W-1:0]     i_cfg_wdata
);
    import trs_pkg::*;

    localparam logic [REG_W-1:0] REG_RESET = REG_W'(1024);
    localparam logic [REG_W-1:0] REG_CLAMP = REG_W'(COORD_MAX);

    logic w_en;

    // configuration
    logic [REG_W-1:0] r_page_width;
    logic [REG_W-1:0] r_page_height;
    logic [REG_W-1:0] w_pw;
    logic [REG_W-1:0] w_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_width  <= REG_RESET;
            r_page_height <= REG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAGE_WIDTH:  r_page_width  <= i_cfg_wdata;
                CFG_PAGE_HEIGHT: r_page_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_pw = (r_page_width  > REG_CLAMP) ? REG_CLAMP : r_page_width;
    assign w_ph = (r_page_height > REG_CLAMP) ? REG_CLAMP : r_page_height;

    assign s_axis_tready = w_en;

    // stage A: capture the transaction
    logic  r_a_vld;
    t_item r_a_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_item.x <= s_axis_tdata[12:0];
            r_a_item.y <= s_axis_tdata[25:13];
            r_a_item.s <= s_axis_tdata[38:26];
            r_a_item.r <= s_axis_tdata[50:39];
        end
    end

    // stage B: side^2, (row+1)*side, x/y bounds
    logic [SQ_W-1:0]   w_sq;
    logic [SIDE_W-1:0] w_rp1;
    logic [NUM_W-1:0]  w_num;
    logic              w_off_xy;
    logic              r_b_vld;
    t_item             r_b_item;
    logic [SQ_W-1:0]   r_b_sq;
    logic [NUM_W-1:0]  r_b_num;
    logic              r_b_off;

    assign w_sq  = SQ_W'(r_a_item.s) * SQ_W'(r_a_item.s);
    assign w_rp1 = SIDE_W'(r_a_item.r) + SIDE_W'(1);
    assign w_num = NUM_W'(SQ_W'(w_rp1) * SQ_W'(r_a_item.s));
    // a negative origin is off already, so unsigned views are safe below
    assign w_off_xy = r_a_item.x[CRD_W-1] | r_a_item.y[CRD_W-1]
                    | ($unsigned(r_a_item.y) > w_ph)
                    | ($unsigned(r_a_item.x) >= w_pw)
                    | ((14'(r_a_item.x[11:0]) + 14'(r_a_item.s)) > 14'(w_pw));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_item <= r_a_item;
            r_b_sq   <= w_sq;
            r_b_num  <= w_num;
            r_b_off  <= w_off_xy;
        end
    end

    // stage C: radicand 3*side^2
    logic             r_c_vld;
    logic [RAD_W-1:0] r_c_rad;
    t_root_sb         r_c_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_rad       <= RAD_W'(r_b_sq) + {1'b0, r_b_sq, 1'b0};
            r_c_sb.item   <= r_b_item;
            r_c_sb.num    <= r_b_num;
            r_c_sb.off_xy <= r_b_off;
        end
    end

    // square root
    logic              w_rt_vld;
    logic [ROOT_W-1:0] w_root;
    t_root_sb          w_rt_sb;

    trs_isqrt #(
        .SB_W ($bits(t_root_sb))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_c_vld),
        .i_rad   (r_c_rad),
        .i_sb    (r_c_sb),
        .o_vld   (w_rt_vld),
        .o_root  (w_root),
        .o_sb    (w_rt_sb)
    );

    // stage D: height, divisor, full bounds check, row gate
    logic [H_W-1:0]   w_h;
    logic             w_off;
    logic             r_d_vld;
    logic [NUM_W-1:0] r_d_num;
    logic [DEN_W-1:0] r_d_den;
    t_span_sb         r_d_sb;

    assign w_h   = w_root[ROOT_W-1:1];
    assign w_off = w_rt_sb.off_xy
                 | ((14'(w_rt_sb.item.y[11:0]) + 14'(w_h)) > 14'(w_ph));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= w_rt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_num     <= w_rt_sb.num;
            r_d_den     <= {w_h, 1'b0};
            r_d_sb.item <= w_rt_sb.item;
            r_d_sb.off  <= w_off;
            // a zero height leaves the divider output unused
            r_d_sb.go   <= ~w_off & (w_h != '0) & (H_W'(w_rt_sb.item.r) < w_h);
        end
    end

    // divider
    logic             w_dv_vld;
    logic [NUM_W-1:0] w_quot;
    logic [DEN_W-1:0] w_rem;
    t_span_sb         w_dv_sb;

    trs_div #(
        .SB_W ($bits(t_span_sb))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_d_vld),
        .i_num   (r_d_num),
        .i_den   (r_d_den),
        .i_sb    (r_d_sb),
        .o_vld   (w_dv_vld),
        .o_quot  (w_quot),
        .o_rem   (w_rem),
        .o_sb    (w_dv_sb)
    );

    // stage E: span ends and emptiness
    logic [NUM_W:0]          w_t1;
    logic signed [NUM_W+1:0] w_s_ext;
    logic signed [NUM_W+1:0] w_last;
    logic                    w_fits;
    logic                    w_valid;
    t_result                 n_res;
    t_result                 r_res;
    logic                    r_res_vld;

    assign w_t1    = (NUM_W+1)'(w_quot) + (NUM_W+1)'(w_rem != '0);
    assign w_s_ext = signed'((NUM_W+2)'(w_dv_sb.item.s));
    // clip to side-1 when the floor term is zero
    assign w_last  = (w_quot == '0) ? (w_s_ext - (NUM_W+2)'(1))
                                    : (w_s_ext - signed'((NUM_W+2)'(w_quot)));
    assign w_fits  = signed'((NUM_W+2)'(w_t1)) <= w_last;
    assign w_valid = w_dv_sb.go & w_fits;

    always_comb begin
        n_res       = '0;
        n_res.off   = w_dv_sb.off;
        n_res.valid = w_valid;
        if (w_valid) begin
            n_res.left  = w_dv_sb.item.x[PIX_W-1:0] + w_t1[PIX_W-1:0];
            n_res.right = w_dv_sb.item.x[PIX_W-1:0] + w_last[PIX_W-1:0];
            n_res.row_y = w_dv_sb.item.y[PIX_W-1:0] + w_dv_sb.item.r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (w_en) begin
            r_res_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
        end
    end

    // output buffer
    t_result w_out;

    trs_out_buf #(
        .W ($bits(t_result))
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en & r_res_vld),
        .i_data  (r_res),
        .i_ready (m_axis_tready),
        .o_space (w_en),
        .o_vld   (m_axis_tvalid),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {4'b0000, w_out.row_y, w_out.right, w_out.left};
    assign m_axis_tuser = {w_out.off, w_out.valid};

endmodule
